@@ rtl/max_heap_priority_queue_defines.svh @@
`ifndef MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// Clocked check, masked while reset is asserted
`define MHPQ_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset
`define MHPQ_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/mhpq_pkg.sv @@
`default_nettype none

package mhpq_pkg;

    localparam int MHPQ_CAPACITY = 1024;
    localparam int VALUE_W       = 31;
    localparam int STATUS_W      = 2;
    localparam int USED_W        = 11;

    // action codes
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED    = 2'd0,
        ST_POPPED    = 2'd1,
        ST_POP_EMPTY = 2'd2,
        ST_PUSH_FULL = 2'd3
    } status_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_TEST,
        S_UP_CMP,
        S_POP_RD,
        S_POP_LD,
        S_DN_TEST,
        S_DN_CMP,
        S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;    // take the input item
        logic up_rd;     // read parent of hole
        logic up_move;   // parent drops into hole, hole climbs
        logic up_place;  // new value lands in hole
        logic pop_rd;    // read root and last entry, shrink count
        logic pop_ld;    // capture root as result, last entry as moving value
        logic dn_rd;     // read both children of hole
        logic dn_move;   // larger child rises into hole, hole descends
        logic dn_place;  // moving value lands in hole
        logic out_load;  // load result register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic up_root;
        logic up_gt;
        logic dn_has_child;
        logic dn_gt;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/mhpq_ctrl.sv @@
`default_nettype none

module mhpq_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 action,
    input  wire mhpq_pkg::dp_status_t stat,
    output mhpq_pkg::cmd_t            cmd,
    output logic                      in_stall
);

    mhpq_pkg::state_t state_reg;
    mhpq_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mhpq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mhpq_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (action == mhpq_pkg::ACT_PUSH)
                    begin
                        state_next = stat.full ? mhpq_pkg::S_OUT : mhpq_pkg::S_UP_TEST;
                    end
                    else
                    begin
                        state_next = stat.empty ? mhpq_pkg::S_OUT : mhpq_pkg::S_POP_RD;
                    end
                end
            end
            mhpq_pkg::S_UP_TEST:
            begin
                state_next = stat.up_root ? mhpq_pkg::S_OUT : mhpq_pkg::S_UP_CMP;
            end
            mhpq_pkg::S_UP_CMP:
            begin
                state_next = stat.up_gt ? mhpq_pkg::S_UP_TEST : mhpq_pkg::S_OUT;
            end
            mhpq_pkg::S_POP_RD:
            begin
                state_next = mhpq_pkg::S_POP_LD;
            end
            mhpq_pkg::S_POP_LD:
            begin
                state_next = mhpq_pkg::S_DN_TEST;
            end
            mhpq_pkg::S_DN_TEST:
            begin
                state_next = stat.dn_has_child ? mhpq_pkg::S_DN_CMP : mhpq_pkg::S_OUT;
            end
            mhpq_pkg::S_DN_CMP:
            begin
                state_next = stat.dn_gt ? mhpq_pkg::S_DN_TEST : mhpq_pkg::S_OUT;
            end
            mhpq_pkg::S_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = mhpq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mhpq_pkg::S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != mhpq_pkg::S_IDLE);
        unique case (state_reg)
            mhpq_pkg::S_IDLE:
            begin
                cmd.accept = in_valid;
            end
            mhpq_pkg::S_UP_TEST:
            begin
                cmd.up_place = stat.up_root;
                cmd.up_rd    = !stat.up_root;
            end
            mhpq_pkg::S_UP_CMP:
            begin
                cmd.up_move  = stat.up_gt;
                cmd.up_place = !stat.up_gt;
            end
            mhpq_pkg::S_POP_RD:
            begin
                cmd.pop_rd = 1'b1;
            end
            mhpq_pkg::S_POP_LD:
            begin
                cmd.pop_ld = 1'b1;
            end
            mhpq_pkg::S_DN_TEST:
            begin
                cmd.dn_rd    = stat.dn_has_child;
                cmd.dn_place = !stat.dn_has_child;
            end
            mhpq_pkg::S_DN_CMP:
            begin
                cmd.dn_move  = stat.dn_gt;
                cmd.dn_place = !stat.dn_gt;
            end
            mhpq_pkg::S_OUT:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/mhpq_datapath.sv @@
`default_nettype none

module mhpq_datapath
#(
    parameter int CAPACITY = mhpq_pkg::MHPQ_CAPACITY
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mhpq_pkg::cmd_t                cmd,
    output mhpq_pkg::dp_status_t               stat,
    input  wire logic                          action,
    input  wire logic [mhpq_pkg::VALUE_W-1:0]  value,
    input  wire logic                          out_stall,
    output logic                               out_valid,
    output logic [mhpq_pkg::VALUE_W-1:0]       result_value,
    output logic [mhpq_pkg::STATUS_W-1:0]      status,
    output logic [mhpq_pkg::USED_W-1:0]        entries_used
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    // heap store, position p lives at address p-1
    logic [mhpq_pkg::VALUE_W-1:0] heap_mem [CAPACITY];
    logic [mhpq_pkg::VALUE_W-1:0] rd_a_reg;
    logic [mhpq_pkg::VALUE_W-1:0] rd_b_reg;
    logic [ADDR_W-1:0]            rd_a_addr;
    logic [ADDR_W-1:0]            rd_b_addr;
    logic                         wr_en;
    logic [ADDR_W-1:0]            wr_addr;
    logic [mhpq_pkg::VALUE_W-1:0] wr_data;

    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic [CNT_W-1:0]             pos_reg;
    logic [CNT_W-1:0]             pos_next;
    logic [mhpq_pkg::VALUE_W-1:0] val_reg;
    logic [mhpq_pkg::VALUE_W-1:0] val_next;
    logic [mhpq_pkg::VALUE_W-1:0] res_reg;
    logic [mhpq_pkg::VALUE_W-1:0] res_next;
    mhpq_pkg::status_t            status_reg;
    mhpq_pkg::status_t            status_next;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [mhpq_pkg::VALUE_W-1:0] out_result_reg;
    logic [mhpq_pkg::VALUE_W-1:0] out_result_next;
    mhpq_pkg::status_t            out_status_reg;
    mhpq_pkg::status_t            out_status_next;
    logic [mhpq_pkg::USED_W-1:0]  out_used_reg;
    logic [mhpq_pkg::USED_W-1:0]  out_used_next;

    logic [CNT_W:0]               child_l;
    logic [CNT_W:0]               child_r;
    logic [CNT_W:0]               count_ext;
    logic [CNT_W-1:0]             parent_pos;
    logic                         right_ok;
    logic                         pick_right;
    logic [mhpq_pkg::VALUE_W-1:0] big_val;
    logic [CNT_W-1:0]             big_pos;

    // tree navigation around the hole
    assign child_l    = {pos_reg, 1'b0};
    assign child_r    = {pos_reg, 1'b1};
    assign count_ext  = {1'b0, count_reg};
    assign parent_pos = pos_reg >> 1;
    assign right_ok   = (child_r <= count_ext);
    // left child wins a tie
    assign pick_right = right_ok && (rd_b_reg > rd_a_reg);
    assign big_val    = pick_right ? rd_b_reg : rd_a_reg;
    assign big_pos    = pick_right ? child_r[CNT_W-1:0] : child_l[CNT_W-1:0];

    // status to controller
    always_comb
    begin
        stat.full         = (count_reg == CNT_W'(CAPACITY));
        stat.empty        = (count_reg == '0);
        stat.up_root      = (pos_reg == CNT_W'(1));
        stat.up_gt        = (val_reg > rd_a_reg);
        stat.dn_has_child = (child_l <= count_ext);
        stat.dn_gt        = (big_val > val_reg);
        stat.out_free     = !out_valid_reg || !out_stall;
    end

    // memory addresses and write data
    always_comb
    begin
        rd_a_addr = '0;
        rd_b_addr = '0;
        if (cmd.up_rd)
        begin
            rd_a_addr = ADDR_W'(parent_pos - 1'b1);
        end
        if (cmd.pop_rd)
        begin
            rd_b_addr = ADDR_W'(count_reg - 1'b1);
        end
        if (cmd.dn_rd)
        begin
            rd_a_addr = ADDR_W'(child_l - 1'b1);
            rd_b_addr = ADDR_W'(child_l);
        end
        wr_en   = cmd.up_move || cmd.up_place || cmd.dn_move || cmd.dn_place;
        wr_addr = ADDR_W'(pos_reg - 1'b1);
        if (cmd.up_move)
        begin
            wr_data = rd_a_reg;
        end
        else if (cmd.dn_move)
        begin
            wr_data = big_val;
        end
        else
        begin
            wr_data = val_reg;
        end
    end

    // heap store, registered reads on two ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= heap_mem[rd_a_addr];
        rd_b_reg <= heap_mem[rd_b_addr];
    end

    // working registers
    always_comb
    begin
        count_next  = count_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        res_next    = res_reg;
        status_next = status_reg;
        if (cmd.accept)
        begin
            res_next = '0;
            if (action == mhpq_pkg::ACT_PUSH)
            begin
                if (stat.full)
                begin
                    status_next = mhpq_pkg::ST_PUSH_FULL;
                end
                else
                begin
                    status_next = mhpq_pkg::ST_PUSHED;
                    count_next  = count_reg + 1'b1;
                    pos_next    = count_reg + 1'b1;
                    val_next    = value;
                end
            end
            else
            begin
                status_next = stat.empty ? mhpq_pkg::ST_POP_EMPTY : mhpq_pkg::ST_POPPED;
            end
        end
        if (cmd.up_move)
        begin
            pos_next = parent_pos;
        end
        if (cmd.pop_rd)
        begin
            count_next = count_reg - 1'b1;
        end
        if (cmd.pop_ld)
        begin
            res_next = rd_a_reg;
            val_next = rd_b_reg;
            pos_next = CNT_W'(1);
        end
        if (cmd.dn_move)
        begin
            pos_next = big_pos;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_result_next = out_result_reg;
        out_status_next = out_status_reg;
        out_used_next   = out_used_reg;
        if (cmd.out_load)
        begin
            out_valid_next  = 1'b1;
            out_result_next = res_reg;
            out_status_next = status_reg;
            out_used_next   = mhpq_pkg::USED_W'(count_reg);
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        res_reg        <= res_next;
        status_reg     <= status_next;
        out_result_reg <= out_result_next;
        out_status_reg <= out_status_next;
        out_used_reg   <= out_used_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_value = out_result_reg;
    assign status       = out_status_reg;
    assign entries_used = out_used_reg;

endmodule

`default_nettype wire

@@ rtl/max_heap_priority_queue.sv @@
// Binary max-heap priority queue.
// Input channel (in_valid / in_stall): action 0 pushes value, action 1 pops
// the maximum. Output channel (out_valid / out_stall): one result per item
// with result_value, status (pushed, popped, pop on empty, push dropped
// because full) and entries_used, the entry count after the item.
// One item is worked on at a time; in_stall is high from the cycle after a
// transfer until the block is idle again.
// A push lets the new value climb from the last position toward the root,
// stopping below a parent that is not smaller; a pop reads the root and the
// last entry, then sinks that entry toward a leaf until it is not smaller
// than its larger child; a dropped push or an empty pop goes straight to the
// result. Each level costs a registered read of the heap store, then a
// compare and a write. The next item can be taken in the same cycle in which
// out_valid rises.
// A stalled result holds in the result register; the next item is still
// taken and, once worked through, waits in the working registers.
// Reset empties the heap (count to zero) and clears out_valid; the store
// itself needs no clearing pass.
`default_nettype none

module max_heap_priority_queue
#(
    parameter int CAPACITY = mhpq_pkg::MHPQ_CAPACITY
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          action,
    input  wire logic [mhpq_pkg::VALUE_W-1:0]  value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [mhpq_pkg::VALUE_W-1:0]       result_value,
    output logic [mhpq_pkg::STATUS_W-1:0]      status,
    output logic [mhpq_pkg::USED_W-1:0]        entries_used
);

    mhpq_pkg::cmd_t       cmd;
    mhpq_pkg::dp_status_t stat;

    mhpq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .stat     (stat),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    mhpq_datapath
    #(
        .CAPACITY (CAPACITY)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .action       (action),
        .value        (value),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .result_value (result_value),
        .status       (status),
        .entries_used (entries_used)
    );

endmodule

`default_nettype wire

@@ rtl/mhpq_checker.sv @@
`default_nettype none

`include "max_heap_priority_queue_defines.svh"

module mhpq_checker
#(
    parameter int CAPACITY = mhpq_pkg::MHPQ_CAPACITY
)
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [mhpq_pkg::VALUE_W-1:0]  result_value,
    input wire logic [mhpq_pkg::STATUS_W-1:0] status,
    input wire logic [mhpq_pkg::USED_W-1:0]   entries_used
);

    localparam int                          WORD_W   = 1 + mhpq_pkg::VALUE_W
                                                       + mhpq_pkg::STATUS_W
                                                       + mhpq_pkg::USED_W;
    localparam logic [mhpq_pkg::USED_W-1:0] USED_CAP = mhpq_pkg::USED_W'(CAPACITY);

    logic [WORD_W-1:0] out_word;
    logic              out_wait;
    logic              res_other;
    logic              empty_pop;
    logic              full_drop;
    logic              in_take;

    // handshake and result views
    assign out_word  = {out_valid, result_value, status, entries_used};
    assign out_wait  = out_valid && out_stall;
    assign res_other = out_valid && (status != mhpq_pkg::ST_POPPED);
    assign empty_pop = out_valid && (status == mhpq_pkg::ST_POP_EMPTY);
    assign full_drop = out_valid && (status == mhpq_pkg::ST_PUSH_FULL);
    assign in_take   = in_valid && !in_stall;

    // a stalled result holds
    `MHPQ_ASSERT(a_out_hold, clk, rst_n, out_wait |=> $stable(out_word), "result moved")

    // only a real pop carries a value
    `MHPQ_ASSERT(a_zero_result, clk, rst_n, res_other |-> result_value == '0, "value on non-pop")

    // a pop on empty reports an empty heap
    `MHPQ_ASSERT(a_empty_count, clk, rst_n, empty_pop |-> entries_used == '0, "count on empty pop")

    // a dropped push reports a full heap
    `MHPQ_ASSERT(a_full_count, clk, rst_n, full_drop |-> entries_used == USED_CAP, "drop not full")

    // one item at a time: busy after every input transfer
    `MHPQ_ASSERT(a_busy_after_take, clk, rst_n, in_take |=> in_stall, "taken while busy")

endmodule

bind max_heap_priority_queue mhpq_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    import mhpq_pkg::*;

    localparam logic [VALUE_W-1:0] VALUE_MAX    = {VALUE_W{1'b1}};
    localparam int                 RANDOM_ITEMS = 822;
    localparam int                 DUE_DEPTH    = 16;

    // one result as the block should produce it
    typedef struct {
        logic [VALUE_W-1:0] val;
        status_t            st;
        logic [USED_W-1:0]  used;
    } heap_result_t;

    // Shadow max-heap: predicts every result and checks the block against it
    class heap_shadow;
        logic [VALUE_W-1:0] heap_mem [1:MHPQ_CAPACITY];
        int                 count;
        heap_result_t       due_ring [DUE_DEPTH];
        int                 due_wr;
        int                 due_rd;
        int                 mismatches;
        int                 checked;
        int                 n_push, n_pop, n_empty, n_dropped, peak;

        function new();
            count      = 0;
            due_wr     = 0;
            due_rd     = 0;
            mismatches = 0;
            checked    = 0;
            n_push     = 0;
            n_pop      = 0;
            n_empty    = 0;
            n_dropped  = 0;
            peak       = 0;
        endfunction

        function int depth();
            return count;
        endfunction

        function int outstanding();
            return due_wr - due_rd;
        endfunction

        // apply one accepted input transfer and queue the result it must give
        function void note_transfer(logic act, logic [VALUE_W-1:0] val);
            heap_result_t       r;
            int                 pos;
            int                 par;
            int                 kid;
            logic [VALUE_W-1:0] t;
            r.val = '0;
            if (act == ACT_PUSH)
            begin
                if (count >= MHPQ_CAPACITY)
                begin
                    r.st = ST_PUSH_FULL;
                    n_dropped++;
                end
                else
                begin
                    count++;
                    pos = count;
                    heap_mem[pos] = val;
                    // climb while strictly greater than the parent
                    while (pos > 1 && heap_mem[pos] > heap_mem[pos / 2])
                    begin
                        t                 = heap_mem[pos];
                        heap_mem[pos]     = heap_mem[pos / 2];
                        heap_mem[pos / 2] = t;
                        pos               = pos / 2;
                    end
                    r.st = ST_PUSHED;
                    n_push++;
                    if (count > peak)
                        peak = count;
                end
            end
            else if (count == 0)
            begin
                r.st = ST_POP_EMPTY;
                n_empty++;
            end
            else
            begin
                r.val       = heap_mem[1];
                heap_mem[1] = heap_mem[count];
                count--;
                par = 1;
                kid = 2;
                // sink toward the larger child, left one on a tie
                while (kid <= count)
                begin
                    if (kid + 1 <= count && heap_mem[kid + 1] > heap_mem[kid])
                        kid++;
                    if (heap_mem[kid] <= heap_mem[par])
                        break;
                    t             = heap_mem[kid];
                    heap_mem[kid] = heap_mem[par];
                    heap_mem[par] = t;
                    par           = kid;
                    kid           = 2 * par;
                end
                r.st = ST_POPPED;
                n_pop++;
            end
            r.used = USED_W'(count);
            due_ring[due_wr % DUE_DEPTH] = r;
            due_wr++;
        endfunction

        // compare one output transfer with the oldest prediction
        function void check_result(logic [VALUE_W-1:0] rv, logic [STATUS_W-1:0] st,
                                   logic [USED_W-1:0] used);
            heap_result_t e;
            if (due_wr == due_rd)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result value=%0d status=%0d used=%0d",
                             $realtime, rv, st, used);
                return;
            end
            e = due_ring[due_rd % DUE_DEPTH];
            due_rd++;
            checked++;
            if (rv !== e.val || st !== e.st || used !== e.used)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result %0d: value %0d/%0d status %0d/%0d %s %0d/%0d",
                             $realtime, checked, e.val, rv, e.st, st,
                             "used (exp/got)", e.used, used);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic                action       = ACT_PUSH;
    logic [VALUE_W-1:0]  value        = '0;
    logic                out_stall    = 1'b0;
    logic                in_stall;
    logic                out_valid;
    logic [VALUE_W-1:0]  result_value;
    logic [STATUS_W-1:0] status;
    logic [USED_W-1:0]   entries_used;

    // no idling on either side while set
    logic                quiet        = 1'b0;

    heap_shadow          book;

    max_heap_priority_queue dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .status       (status),
        .entries_used (entries_used)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // output side: random stall, sample each transfer
    always @(posedge clk)
    begin
        out_stall <= !quiet && ($urandom_range(99) < 14);
        if (rst_n && out_valid && !out_stall)
            book.check_result(result_value, status, entries_used);
    end

    // mostly full-range values, with ties, zero and the top of the range
    function automatic logic [VALUE_W-1:0] pick_value();
        int sel = $urandom_range(99);
        if (sel < 55)
            return VALUE_W'($urandom);
        else if (sel < 80)
            return VALUE_W'($urandom_range(15));
        else if (sel < 88)
            return '0;
        else if (sel < 95)
            return VALUE_MAX;
        else
            return VALUE_MAX - VALUE_W'($urandom_range(7));
    endfunction

    // present one item, optionally after idle cycles, and wait for its transfer
    task automatic send_item(input logic act, input logic [VALUE_W-1:0] val);
        while (!quiet && $urandom_range(99) < 14)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        value    <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        book.note_transfer(act, val);
    endtask

    initial
    begin
        int sent;
        int phase_no;
        int phase_len;
        int push_pct;
        int sel;

        book = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pops, zero, ties, range extremes, full drain
        send_item(ACT_POP,  VALUE_MAX);
        send_item(ACT_PUSH, '0);
        send_item(ACT_POP,  '0);
        send_item(ACT_POP,  '0);
        send_item(ACT_PUSH, 31'd5);
        send_item(ACT_PUSH, 31'd5);
        send_item(ACT_PUSH, 31'd5);
        send_item(ACT_PUSH, VALUE_MAX);
        send_item(ACT_PUSH, '0);
        send_item(ACT_PUSH, 31'd1);
        send_item(ACT_PUSH, VALUE_MAX - 1'b1);
        send_item(ACT_PUSH, VALUE_MAX);
        send_item(ACT_PUSH, 31'h2AAA_AAAA);
        send_item(ACT_PUSH, 31'h5555_5555);
        repeat (11)
            send_item(ACT_POP, pick_value());

        // random phases: growing, balanced or shrinking heap
        sent     = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS)
        begin
            phase_len = $urandom_range(60, 140);
            sel       = $urandom_range(99);
            push_pct  = (sel < 50) ? 80 : (sel < 75) ? 55 : 25;
            quiet     = (phase_no == 2);
            repeat (phase_len)
            begin
                if (sent < RANDOM_ITEMS)
                begin
                    if ($urandom_range(99) < push_pct)
                        send_item(ACT_PUSH, pick_value());
                    else
                        send_item(ACT_POP, pick_value());
                    sent++;
                end
            end
            phase_no++;
        end
        quiet = 1'b0;

        // a few closing pops
        repeat (3)
            send_item(ACT_POP, pick_value());

        @(posedge clk);
        in_valid <= 1'b0;

        // let the last results come out, then allow a few more cycles
        while (book.outstanding() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Covered %0d pushes, %0d pops, %0d pops on empty, %0d dropped pushes",
                 book.n_push, book.n_pop, book.n_empty, book.n_dropped);
        $display("Heap peaked at %0d entries; %0d results checked, %0d mismatches",
                 book.peak, book.checked, book.mismatches);
        if (book.mismatches == 0 && book.outstanding() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
